// ===== hw/rtl/b2s_pkg.sv =====
// Package: shared types, constants and permutation table for the BLAKE2s engine
`default_nettype none
package b2s_pkg;

  localparam int unsigned NumRounds   = 10;
  localparam int unsigned BlockBytes  = 64;
  localparam int unsigned DigestMax   = 32;

  localparam logic [1:0] RegDigestLen = 2'd0;
  localparam logic [1:0] RegKeyLen    = 2'd1;

  localparam logic REQ_ABSORB   = 1'b0;
  localparam logic REQ_FINALIZE = 1'b1;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic       init_msg;    // rebuild chain value, clear counters
    logic       write_byte;  // store input byte in buffer
    logic       start_comp;  // load working vector
    logic       final_blk;   // final-block flag for start_comp
    logic       mix_step;    // run one G function
    logic       fold;        // fold working vector into chain value
    logic       emit_next;   // advance digest byte pointer
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       buf_full;
    logic       last_mix;
    logic       last_emit;
  } dp_sts_t;

  function automatic word_t iv_word(input logic [2:0] i);
    word_t w;
    case (i)
      3'd0: w = 32'h6A09E667;
      3'd1: w = 32'hBB67AE85;
      3'd2: w = 32'h3C6EF372;
      3'd3: w = 32'hA54FF53A;
      3'd4: w = 32'h510E527F;
      3'd5: w = 32'h9B05688C;
      3'd6: w = 32'h1F83D9AB;
      3'd7: w = 32'h5BE0CD19;
      default: w = '0;
    endcase
    return w;
  endfunction

  // message word index, round r, position p (0..15)
  function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] p);
    logic [63:0] row;
    case (r)
      4'd0: row = 64'hFEDCBA9876543210;
      4'd1: row = 64'h357B20C16DF984AE;
      4'd2: row = 64'h491763EADF250C8B;
      4'd3: row = 64'h8F04A562EBCD1397;
      4'd4: row = 64'hD386CB1EFA427509;
      4'd5: row = 64'h91EF57D438B0A6C2;
      4'd6: row = 64'hB8293670A4DEF15C;
      4'd7: row = 64'hA2684F05931CE7BD;
      4'd8: row = 64'h5A417D2C803B9EF6;
      4'd9: row = 64'h0DC3E9BF5167482A;
      default: row = '0;
    endcase
    return row[p*4 +: 4];
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/b2s_ctrl.sv =====
// Controller: sequences absorb, compression rounds, fold and digest emission
`default_nettype none
module b2s_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_fire_i,
  input  wire logic            in_req_i,
  input  wire logic            cfg_wr_i,
  input  wire logic            out_slot_free_i,
  input  wire b2s_pkg::dp_sts_t sts_i,
  output b2s_pkg::dp_cmd_t     cmd_o,
  output logic                 in_ready_o,
  output logic                 out_load_o
);
  import b2s_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        fin_q, fin_d;      // compression belongs to a finalize
  logic        pend_q, pend_d;    // absorbed byte waits for compression

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fin_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    fin_d      = fin_q;
    pend_d     = pend_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.init_msg = cfg_wr_i;
        if (in_fire_i) begin
          if (in_req_i == REQ_FINALIZE) begin
            cmd_o.start_comp = 1'b1;
            cmd_o.final_blk  = 1'b1;
            fin_d   = 1'b1;
            state_d = ST_ROUND;
          end else if (sts_i.buf_full) begin
            cmd_o.start_comp = 1'b1;
            fin_d   = 1'b0;
            pend_d  = 1'b1;
            state_d = ST_ROUND;
          end else begin
            cmd_o.write_byte = 1'b1;
          end
        end
      end
      ST_ROUND: begin
        cmd_o.mix_step = 1'b1;
        if (sts_i.last_mix) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        if (fin_q) begin
          state_d = ST_EMIT;
        end else begin
          // start_comp cleared fill count; pending byte goes in next
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_slot_free_i) begin
          out_load_o      = 1'b1;
          cmd_o.emit_next = 1'b1;
          if (sts_i.last_emit) begin
            cmd_o.init_msg = 1'b1;
            fin_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // byte that triggered a compression is written right after the fold
    if (state_q == ST_IDLE && pend_q) begin
      in_ready_o       = 1'b0;
      cmd_o.write_byte = 1'b1;
      cmd_o.init_msg   = 1'b0;
      cmd_o.start_comp = 1'b0;
      pend_d  = 1'b0;
      state_d = ST_IDLE;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/b2s_datapath.sv =====
// Datapath: block buffer, chain value, working vector with one G unit
`default_nettype none
module b2s_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire b2s_pkg::dp_cmd_t cmd_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic [5:0]       digest_length_i,
  input  wire logic [5:0]       key_length_i,
  output b2s_pkg::dp_sts_t      sts_o,
  output logic [7:0]            digest_byte_o,
  output logic [4:0]            byte_index_o,
  output logic                  last_byte_o
);
  import b2s_pkg::*;

  // block buffer as 16 words, byte-written
  word_t       m_q [16];
  word_t       h_q [8];
  word_t       v_q [16];
  logic [6:0]  fill_q;
  logic [63:0] cnt_q;
  logic [3:0]  round_q;
  logic [2:0]  g_q;
  logic [4:0]  emit_q;

  logic [5:0]  dlen, klen;
  logic [4:0]  dlast;
  logic [63:0] cnt_fin;

  assign dlen  = (digest_length_i == 6'd0) ? 6'd1 :
                 (digest_length_i > 6'd32) ? 6'd32 : digest_length_i;
  assign klen  = (key_length_i > 6'd32) ? 6'd32 : key_length_i;
  assign dlast = 5'(dlen - 6'd1);
  assign cnt_fin = cnt_q + 64'(fill_q);

  assign sts_o.buf_full  = fill_q[6];
  assign sts_o.last_mix  = (round_q == 4'(NumRounds - 1)) && (g_q == 3'd7);
  assign sts_o.last_emit = (emit_q == dlast);

  // G operand selection
  logic [3:0] ia, ib, ic, id;
  word_t      a0, b0, c0, d0, mx, my, a1, d1, c1, b1, a2, d2, c2, b2;
  always_comb begin
    case (g_q)
      3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
      3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
      3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
      3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
      3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
      3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
      3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
      default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
    endcase
    a0 = v_q[ia]; b0 = v_q[ib]; c0 = v_q[ic]; d0 = v_q[id];
    mx = m_q[sigma(round_q, {g_q, 1'b0})];
    my = m_q[sigma(round_q, {g_q, 1'b1})];
    a1 = a0 + b0 + mx;
    d1 = rotr(d0 ^ a1, 16);
    c1 = c0 + d1;
    b1 = rotr(b0 ^ c1, 12);
    a2 = a1 + b1 + my;
    d2 = rotr(d1 ^ a2, 8);
    c2 = c1 + d2;
    b2 = rotr(b1 ^ c2, 7);
  end

  // control counters and chain value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= iv_word(3'(i));
      h_q[0]  <= iv_word(3'd0) ^ 32'h0101_0020;
      fill_q  <= '0;
      cnt_q   <= '0;
      round_q <= '0;
      g_q     <= '0;
      emit_q  <= '0;
    end else begin
      if (cmd_i.init_msg) begin
        for (int i = 1; i < 8; i++) h_q[i] <= iv_word(3'(i));
        h_q[0] <= iv_word(3'd0) ^ {8'h01, 8'h01, 2'b00, klen, 2'b00, dlen};
        fill_q <= '0;
        cnt_q  <= '0;
        emit_q <= '0;
      end
      if (cmd_i.write_byte) fill_q <= fill_q + 7'd1;
      if (cmd_i.start_comp) begin
        round_q <= '0;
        g_q     <= '0;
        cnt_q   <= cmd_i.final_blk ? cnt_fin : cnt_q + 64'(BlockBytes);
        fill_q  <= cmd_i.final_blk ? fill_q : 7'd0;
      end
      if (cmd_i.mix_step) begin
        g_q <= g_q + 3'd1;
        if (g_q == 3'd7) round_q <= round_q + 4'd1;
      end
      if (cmd_i.fold)
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i+8];
      // last digest beat restarts the pointer through init_msg
      if (cmd_i.emit_next && !cmd_i.init_msg) emit_q <= emit_q + 5'd1;
    end
  end

  // buffer, zero padding on finalize, working vector
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_byte)
      m_q[fill_q[5:2]][fill_q[1:0]*8 +: 8] <= data_byte_i;
    if (cmd_i.start_comp) begin
      if (cmd_i.final_blk && !fill_q[6]) begin
        for (int w = 0; w < 16; w++)
          for (int b = 0; b < 4; b++)
            if (7'(w*4 + b) >= fill_q) m_q[w][b*8 +: 8] <= 8'h00;
      end
      for (int i = 0; i < 8; i++) begin
        v_q[i]   <= h_q[i];
        v_q[i+8] <= iv_word(3'(i));
      end
      v_q[12] <= iv_word(3'd4) ^ (cmd_i.final_blk ? cnt_fin[31:0]
                                                 : 32'(cnt_q + 64'(BlockBytes)));
      v_q[13] <= iv_word(3'd5) ^ (cmd_i.final_blk ? cnt_fin[63:32]
                                 : 32'((cnt_q + 64'(BlockBytes)) >> 32));
      v_q[14] <= iv_word(3'd6) ^ {32{cmd_i.final_blk}};
    end
    if (cmd_i.mix_step) begin
      v_q[ia] <= a2; v_q[ib] <= b2; v_q[ic] <= c2; v_q[id] <= d2;
    end
  end

  // current digest byte
  word_t ow;
  assign ow            = h_q[emit_q[4:2]];
  assign digest_byte_o = ow[emit_q[1:0]*8 +: 8];
  assign byte_index_o  = emit_q;
  assign last_byte_o   = sts_o.last_emit;
endmodule
`default_nettype wire

// ===== hw/rtl/blake2s_hash_engine_unit.sv =====
// Top level: BLAKE2s engine with stream ports and APB register port
//
// Channel | Dir | tdata / tuser fields (LSB first)
// s_axis  | in  | tdata: data_byte[7:0]; tuser: req_type
// m_axis  | out | tdata: digest_byte[7:0], byte_index[12:8]; tlast: last_byte
// apb     | cfg | 0x0 digest_length, 0x4 key_length
//
// An absorb beat into a buffer that is not full is written directly; the beat
// that arrives on a full buffer starts a compression: 80 G steps, fold and the
// deferred byte write keep s_axis_tready low.
// Finalize: compression and fold, then one digest beat per cycle while the output slot is free.
// The output register lets a beat wait while the next one is prepared.
// Reset sets the chain value from the default parameter block.
`default_nettype none
module blake2s_hash_engine_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tuser,   // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // digest_byte, byte_index, zero pad
  output logic             m_axis_tlast,   // last_byte
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import b2s_pkg::*;

  logic [5:0] dlen_q, klen_q;
  logic [5:0] dlen_nx, klen_nx;
  logic       wr, wr_d, wr_k, in_fire, slot_free, out_load;
  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [7:0] db;
  logic [4:0] bi;
  logic       lb;

  assign pready = 1'b1;
  assign wr   = psel && penable && pwrite;
  assign wr_d = wr && (paddr[2] == RegDigestLen[0]) && (paddr[1:0] == 2'b00);
  assign wr_k = wr && (paddr[2] == RegKeyLen[0]) && (paddr[1:0] == 2'b00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dlen_q <= 6'd32;
      klen_q <= 6'd0;
    end else begin
      if (wr_d) dlen_q <= pwdata[5:0];
      if (wr_k) klen_q <= pwdata[5:0];
    end
  end

  // restart on a write builds the parameter block from the value being written
  assign dlen_nx = wr_d ? pwdata[5:0] : dlen_q;
  assign klen_nx = wr_k ? pwdata[5:0] : klen_q;

  always_comb begin
    prdata = '0;
    if (paddr == 3'd0) prdata = {26'd0, dlen_q};
    else if (paddr == 3'd4) prdata = {26'd0, klen_q};
  end

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign slot_free = !m_axis_tvalid || m_axis_tready;

  b2s_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(in_fire), .in_req_i(s_axis_tuser), .cfg_wr_i(wr_d || wr_k),
    .out_slot_free_i(slot_free), .sts_i(sts), .cmd_o(cmd),
    .in_ready_o(s_axis_tready), .out_load_o(out_load)
  );

  // the byte for a deferred write is held until after the compression
  logic [7:0] byte_q, byte_mux;
  always_ff @(posedge clk_i) if (in_fire) byte_q <= s_axis_tdata;
  assign byte_mux = in_fire ? s_axis_tdata : byte_q;

  b2s_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .data_byte_i(byte_mux),
    .digest_length_i(dlen_nx), .key_length_i(klen_nx), .sts_o(sts),
    .digest_byte_o(db), .byte_index_o(bi), .last_byte_o(lb)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid <= 1'b0;
    else if (out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata <= {3'b000, bi, db};
      m_axis_tlast <= lb;
    end
  end
endmodule
`default_nettype wire

// ===== verif/blake2s_hash_engine_unit_tb.sv =====
// Testbench for the BLAKE2s engine: stream stimulus, in-bench hash predictor, APB setup
`timescale 1ns / 1ps
module blake2s_hash_engine_unit_tb;
  import b2s_pkg::*;

  typedef struct packed {
    logic       req;
    logic [7:0] data;
  } req_beat_t;

  typedef struct packed {
    logic [7:0] dbyte;
    logic [4:0] idx;
    logic       last;
  } digest_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  blake2s_hash_engine_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Predictor state
  logic [31:0]  hash_h[8];
  logic [7:0]   msg_buf[64];
  int unsigned  msg_fill;
  logic [63:0]  msg_count;
  logic [5:0]   cfg_dlen;
  logic [5:0]   cfg_klen;

  req_beat_t    pending_reqs[$];
  digest_beat_t digest_fifo[$];
  int           err_count;
  int           digests_seen;
  int           beats_sent;
  bit           hold_sender;
  bit           stim_done;
  int           gap_left;
  int           burst_left;
  int           stall_mode;

  localparam logic [63:0] SIGMA_ROWS [10] = '{
    64'hFEDCBA9876543210, 64'h357B20C16DF984AE, 64'h491763EADF250C8B,
    64'h8F04A562EBCD1397, 64'hD386CB1EFA427509, 64'h91EF57D438B0A6C2,
    64'hB8293670A4DEF15C, 64'hA2684F05931CE7BD, 64'h5A417D2C803B9EF6,
    64'h0DC3E9BF5167482A};
  localparam logic [31:0] IV_TAB [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

  function automatic int unsigned eff_dlen();
    if (cfg_dlen == 0) return 1;
    if (cfg_dlen > 32) return 32;
    return cfg_dlen;
  endfunction

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic restart_hash();
    int unsigned klen;
    klen = (cfg_klen > 32) ? 32 : cfg_klen;
    for (int i = 0; i < 8; i++) hash_h[i] = IV_TAB[i];
    hash_h[0] ^= eff_dlen() | (klen << 8) | (32'd1 << 16) | (32'd1 << 24);
    msg_fill  = 0;
    msg_count = '0;
  endtask

  task automatic gmix(ref logic [31:0] v[16], input int a, int b, int c, int d,
                      input logic [31:0] x, logic [31:0] y);
    v[a] = v[a] + v[b] + x;
    v[d] = ror32(v[d] ^ v[a], 16);
    v[c] = v[c] + v[d];
    v[b] = ror32(v[b] ^ v[c], 12);
    v[a] = v[a] + v[b] + y;
    v[d] = ror32(v[d] ^ v[a], 8);
    v[c] = v[c] + v[d];
    v[b] = ror32(v[b] ^ v[c], 7);
  endtask

  task automatic compress_block(input bit fin);
    logic [31:0] m[16];
    logic [31:0] v[16];
    logic [63:0] row;
    for (int i = 0; i < 16; i++)
      m[i] = {msg_buf[4*i+3], msg_buf[4*i+2], msg_buf[4*i+1], msg_buf[4*i]};
    for (int i = 0; i < 8; i++) begin
      v[i]   = hash_h[i];
      v[i+8] = IV_TAB[i];
    end
    v[12] ^= msg_count[31:0];
    v[13] ^= msg_count[63:32];
    if (fin) v[14] = ~v[14];
    for (int r = 0; r < 10; r++) begin
      row = SIGMA_ROWS[r];
      gmix(v, 0, 4, 8, 12, m[row[3:0]], m[row[7:4]]);
      gmix(v, 1, 5, 9, 13, m[row[11:8]], m[row[15:12]]);
      gmix(v, 2, 6, 10, 14, m[row[19:16]], m[row[23:20]]);
      gmix(v, 3, 7, 11, 15, m[row[27:24]], m[row[31:28]]);
      gmix(v, 0, 5, 10, 15, m[row[35:32]], m[row[39:36]]);
      gmix(v, 1, 6, 11, 12, m[row[43:40]], m[row[47:44]]);
      gmix(v, 2, 7, 8, 13, m[row[51:48]], m[row[55:52]]);
      gmix(v, 3, 4, 9, 14, m[row[59:56]], m[row[63:60]]);
    end
    for (int i = 0; i < 8; i++) hash_h[i] ^= v[i] ^ v[i+8];
  endtask

  // Advance the predictor by one accepted input beat
  task automatic predict_beat(input req_beat_t b);
    int unsigned len;
    digest_beat_t e;
    if (b.req == REQ_ABSORB) begin
      if (msg_fill >= 64) begin
        msg_count += 64;
        compress_block(1'b0);
        msg_fill = 0;
      end
      msg_buf[msg_fill] = b.data;
      msg_fill++;
    end else begin
      msg_count += msg_fill;
      for (int i = msg_fill; i < 64; i++) msg_buf[i] = '0;
      compress_block(1'b1);
      len = eff_dlen();
      for (int i = 0; i < len; i++) begin
        e.dbyte = 8'(hash_h[i/4] >> (8 * (i % 4)));
        e.idx   = 5'(i);
        e.last  = (i + 1 == len);
        digest_fifo.push_back(e);
      end
      restart_hash();
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    err_count++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sender: bursts with random gaps, optional hold until drained
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      gap_left      <= 0;
      burst_left    <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_beat(pending_reqs.pop_front());
        beats_sent++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold current beat
      end else if ((hold_sender && digest_fifo.size() != 0) ||
                   pending_reqs.size() == 0 || gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_reqs[0].data;
        s_axis_tuser  <= pending_reqs[0].req;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver stall pattern and digest checker
  always @(posedge clk_i or negedge rst_ni) begin
    digest_beat_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_fifo.size() == 0) begin
          report_mismatch($sformatf("unexpected digest beat %h", m_axis_tdata));
        end else begin
          e = digest_fifo.pop_front();
          digests_seen++;
          if (m_axis_tdata[7:0] !== e.dbyte)
            report_mismatch($sformatf("digest_byte %h exp %h idx %0d",
                                      m_axis_tdata[7:0], e.dbyte, e.idx));
          if (m_axis_tdata[12:8] !== e.idx)
            report_mismatch($sformatf("byte_index %0d exp %0d",
                                      m_axis_tdata[12:8], e.idx));
          if (m_axis_tlast !== e.last)
            report_mismatch($sformatf("last_byte %b exp %b idx %0d",
                                      m_axis_tlast, e.last, e.idx));
        end
      end
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == 3'd0) cfg_dlen = val[5:0];
    else if (addr == 3'd4) cfg_klen = val[5:0];
    restart_hash();
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_axis_tvalid || digest_fifo.size() != 0)
      @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic push_msg(input int nbytes, input bit fin);
    req_beat_t b;
    for (int i = 0; i < nbytes; i++) begin
      b.req  = REQ_ABSORB;
      b.data = $urandom_range(0, 255);
      pending_reqs.push_back(b);
    end
    if (fin) begin
      b.req  = REQ_FINALIZE;
      b.data = $urandom_range(0, 255);
      pending_reqs.push_back(b);
    end
  endtask

  // Stimulus phases
  initial begin
    req_beat_t b;
    int n;
    int phase_len[4];
    logic [5:0] dl_set[4];
    logic [5:0] kl_set[4];
    err_count = 0; digests_seen = 0; beats_sent = 0;
    hold_sender = 1'b0; stim_done = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cfg_dlen = 6'd32; cfg_klen = 6'd0;
    restart_hash();
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, byte extremes and a ten-byte message
    push_msg(0, 1'b1);
    b.req = REQ_ABSORB; b.data = 8'h00; pending_reqs.push_back(b);
    b.data = 8'hFF; pending_reqs.push_back(b);
    b.data = 8'hA5; pending_reqs.push_back(b);
    b.req = REQ_FINALIZE; b.data = 8'hFF; pending_reqs.push_back(b);
    push_msg(10, 1'b1);
    wait_drained();

    // Hold the sender after each finalize until its digest has returned
    hold_sender = 1'b1;
    push_msg(64, 1'b1);
    push_msg(65, 1'b1);
    wait_drained();
    hold_sender = 1'b0;
    wait_drained();

    // Register settings, extremes and out-of-range values
    dl_set = '{6'd1, 6'd0, 6'd63, 6'd17};
    kl_set = '{6'd32, 6'd63, 6'd0, 6'd5};
    for (int p = 0; p < 4; p++) begin
      apb_write(3'd0, {26'd0, dl_set[p]});
      apb_write(3'd4, {26'd0, kl_set[p]});
      apb_write(3'd0, 32'hFFFF_FF00 | dl_set[p]);
      // short random messages
      for (int k = 0; k < 2; k++) begin
        n = $urandom_range(0, 3);
        push_msg(n, 1'b1);
      end
      wait_drained();
    end
    apb_write(3'd0, 32'd32);
    apb_write(3'd4, 32'd0);
    push_msg($urandom_range(0, 4), 1'b1);
    wait_drained();
    stim_done = 1'b1;

    $display("Sent %0d beats, checked %0d digest bytes across four register settings",
             beats_sent, digests_seen);
    $display("Covered empty, partial, full and multi-block messages with keyed lengths");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout waiting for digest beats");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
